FILE: src/mwc_pkg.sv
`timescale 1ns / 1ps

package mwc_pkg;

  localparam int unsigned MAX_BINS_DEF = 8192;
  localparam logic [15:0] WINDOW_RESET = 16'd480;
  localparam logic [15:0] CAND_MAX = 16'd32768;
  localparam logic [15:0] CORR_POS_MAX = 16'd32767;
  localparam int unsigned FRAC_SHIFT = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_LOAD,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NSAB,
    OP_KSA,
    OP_KSASB,
    OP_NSAA,
    OP_KSASA,
    OP_NSBB,
    OP_KSB,
    OP_KSBSB,
    OP_XY,
    OP_NUM2,
    OP_CAND
  } op_t;

endpackage

FILE: src/masked_waveform_correlation.sv
`timescale 1ns / 1ps
// sequence: bins load one per cycle while idle; after the last bin come a setup state, a scan
// through the sample memory, then ten wide products and sixteen root search steps on a
// bit-serial shift-add multiplier, one multiplier bit per cycle; a degenerate or zero
// numerator ends after the eighth product; the done state then presents the result
// throughput: one bin per cycle while loading; no bin is taken from the last bin until the
// result is presented; reset: counts, sums, the overflow flag and handshakes clear, memory is kept

module masked_waveform_correlation #(
  parameter int unsigned MAX_BINS = mwc_pkg::MAX_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample_a,
  input  logic signed [15:0] sample_b,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] correlation,
  output logic               degenerate,
  output logic               overflowed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  localparam int unsigned CW = $clog2(MAX_BINS + 1);
  localparam int unsigned AW = $clog2(MAX_BINS);
  localparam int unsigned SUM_W = CW + 16;
  localparam int unsigned ACC_W = CW + 31;
  localparam int unsigned TW = 3 * CW + 31;
  localparam int unsigned TS = TW + 1;
  localparam int unsigned PW = 2 * TW + 32;
  localparam int unsigned MB_W = TW;
  localparam int unsigned DW = CW + 18;
  localparam int unsigned WIN_W = CW + 16;
  localparam int unsigned N2_W = 2 * CW;

  mwc_pkg::state_t state, state_next;
  mwc_pkg::op_t    op;

  logic [15:0]              window;
  logic [CW-1:0]            count;
  logic signed [SUM_W-1:0]  sum_a, sum_b;
  logic                     overflow_seen;
  logic                     full;

  logic [31:0]              mem [MAX_BINS];
  logic [31:0]              q;
  logic [CW-1:0]            rd_idx;
  logic                     rd_v1, rd_v2;

  logic [WIN_W-1:0]         win;
  logic [N2_W-1:0]          n2;
  logic signed [DW-1:0]     da, db;
  logic signed [31:0]       pab, paa, pbb;
  logic signed [ACC_W-1:0]  sab, saa, sbb;
  logic [CW-1:0]            k;

  logic [PW-1:0]            ma, mp;
  logic [MB_W-1:0]          mb;
  logic [TW-1:0]            term_p, tmp;
  logic signed [TS-1:0]     num, vx;
  logic [2*TW-1:0]          xy;
  logic [PW-1:0]            lhs;
  logic [15:0]              lo;
  logic [3:0]               bit_idx;
  logic                     degen;

  logic                     in_acc;
  logic                     mul_done;
  logic [SUM_W-1:0]         sa_mag, sb_mag;
  logic [ACC_W-1:0]         sab_mag;
  logic signed [CW:0]       n_s;
  logic signed [CW+16:0]    na_c, nb_c;
  logic signed [DW-1:0]     da_c, db_c;
  logic [DW-1:0]            da_mag, db_mag;
  logic signed [TS-1:0]     p_s, q_s, diff_c, num_c;
  logic [TW-1:0]            num_mag, vx_mag, vy_mag;
  logic                     degen_c;
  logic [15:0]              cand;
  logic [16:0]              t_c;
  logic [33:0]              t2_c;
  logic [PW-1:0]            ld_a;
  logic [MB_W-1:0]          ld_b;

  assign in_ready = (state == mwc_pkg::ST_IDLE);
  assign in_acc = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign full = (count == CW'(MAX_BINS));
  assign mul_done = (mb == '0);

  assign sa_mag = sum_a[SUM_W-1] ? SUM_W'(~sum_a + 1'b1) : SUM_W'(sum_a);
  assign sb_mag = sum_b[SUM_W-1] ? SUM_W'(~sum_b + 1'b1) : SUM_W'(sum_b);
  assign sab_mag = sab[ACC_W-1] ? ACC_W'(~sab + 1'b1) : ACC_W'(sab);

  // mask stage
  assign n_s = signed'({1'b0, count});
  assign na_c = n_s * signed'(q[15:0]);
  assign nb_c = n_s * signed'(q[31:16]);
  assign da_c = DW'(na_c) - DW'(sum_a);
  assign db_c = DW'(nb_c) - DW'(sum_b);
  assign da_mag = da[DW-1] ? DW'(~da + 1'b1) : DW'(da);
  assign db_mag = db[DW-1] ? DW'(~db + 1'b1) : DW'(db);

  // term combine
  assign p_s = signed'({1'b0, term_p});
  assign q_s = signed'({1'b0, mp[TW-1:0]});
  assign diff_c = p_s - q_s;
  assign num_c = (sab[ACC_W-1] ? -p_s : p_s)
               - ((sum_a[SUM_W-1] ^ sum_b[SUM_W-1]) ? -q_s : q_s);
  assign num_mag = num[TS-1] ? TW'(~num + 1'b1) : TW'(num);
  assign vx_mag = vx[TS-1] ? TW'(~vx + 1'b1) : TW'(vx);
  assign vy_mag = diff_c[TS-1] ? TW'(~diff_c + 1'b1) : TW'(diff_c);
  assign degen_c = (count == '0) || (vx == '0) || (diff_c == '0)
                 || (vx[TS-1] != diff_c[TS-1]);

  // root search candidate
  assign cand = lo | (16'd1 << bit_idx);
  assign t_c = {cand, 1'b0} - 17'd1;
  assign t2_c = t_c * t_c;

  always_comb begin
    ld_a = '0;
    ld_b = '0;
    case (op)
      mwc_pkg::OP_NSAB: begin
        ld_a = PW'(n2);
        ld_b = MB_W'(sab_mag);
      end
      mwc_pkg::OP_KSA: begin
        ld_a = PW'(sa_mag);
        ld_b = MB_W'(k);
      end
      mwc_pkg::OP_KSASB: begin
        ld_a = PW'(tmp);
        ld_b = MB_W'(sb_mag);
      end
      mwc_pkg::OP_NSAA: begin
        ld_a = PW'(n2);
        ld_b = MB_W'(saa);
      end
      mwc_pkg::OP_KSASA: begin
        ld_a = PW'(tmp);
        ld_b = MB_W'(sa_mag);
      end
      mwc_pkg::OP_NSBB: begin
        ld_a = PW'(n2);
        ld_b = MB_W'(sbb);
      end
      mwc_pkg::OP_KSB: begin
        ld_a = PW'(sb_mag);
        ld_b = MB_W'(k);
      end
      mwc_pkg::OP_KSBSB: begin
        ld_a = PW'(tmp);
        ld_b = MB_W'(sb_mag);
      end
      mwc_pkg::OP_XY: begin
        ld_a = PW'(vx_mag);
        ld_b = MB_W'(term_p);
      end
      mwc_pkg::OP_NUM2: begin
        ld_a = PW'(num_mag);
        ld_b = MB_W'(num_mag);
      end
      mwc_pkg::OP_CAND: begin
        ld_a = PW'(xy);
        ld_b = MB_W'(t2_c);
      end
      default: begin
        ld_a = '0;
        ld_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mwc_pkg::ST_IDLE: begin
        if (in_acc && last_sample) begin
          state_next = mwc_pkg::ST_SETUP;
        end
      end
      mwc_pkg::ST_SETUP: state_next = mwc_pkg::ST_SCAN;
      mwc_pkg::ST_SCAN: begin
        if (rd_idx == count && !rd_v1 && !rd_v2) begin
          state_next = mwc_pkg::ST_LOAD;
        end
      end
      mwc_pkg::ST_LOAD: state_next = mwc_pkg::ST_MUL;
      mwc_pkg::ST_MUL: begin
        if (mul_done) begin
          case (op)
            mwc_pkg::OP_KSBSB: begin
              state_next = (degen_c || num == '0) ? mwc_pkg::ST_DONE : mwc_pkg::ST_LOAD;
            end
            mwc_pkg::OP_CAND: begin
              state_next = (bit_idx == '0) ? mwc_pkg::ST_DONE : mwc_pkg::ST_LOAD;
            end
            default: state_next = mwc_pkg::ST_LOAD;
          endcase
        end
      end
      mwc_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = mwc_pkg::ST_IDLE;
        end
      end
      default: state_next = mwc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && !full) begin
      mem[count[AW-1:0]] <= {sample_b, sample_a};
    end
    q <= mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= mwc_pkg::WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum_a <= '0;
      sum_b <= '0;
      overflow_seen <= 1'b0;
      out_valid <= 1'b0;
      rd_v1 <= 1'b0;
      rd_v2 <= 1'b0;
      rd_idx <= '0;
      op <= mwc_pkg::OP_NSAB;
    end else begin
      if (out_valid && out_ready && state != mwc_pkg::ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        mwc_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (full) begin
              overflow_seen <= 1'b1;
            end else begin
              count <= count + 1'b1;
              sum_a <= sum_a + SUM_W'(sample_a);
              sum_b <= sum_b + SUM_W'(sample_b);
            end
          end
        end
        mwc_pkg::ST_SETUP: begin
          win <= WIN_W'(count) * WIN_W'(window);
          n2 <= N2_W'(count) * N2_W'(count);
          sab <= '0;
          saa <= '0;
          sbb <= '0;
          k <= '0;
          rd_idx <= '0;
          rd_v1 <= 1'b0;
          rd_v2 <= 1'b0;
          op <= mwc_pkg::OP_NSAB;
        end
        mwc_pkg::ST_SCAN: begin
          // read, then mask and products, then accumulate
          rd_v1 <= (rd_idx != count);
          if (rd_idx != count) begin
            rd_idx <= rd_idx + 1'b1;
          end
          rd_v2 <= rd_v1;
          da <= da_c;
          db <= db_c;
          pab <= signed'(q[15:0]) * signed'(q[31:16]);
          paa <= signed'(q[15:0]) * signed'(q[15:0]);
          pbb <= signed'(q[31:16]) * signed'(q[31:16]);
          if (rd_v2 && (DW'(win) > da_mag) && (DW'(win) > db_mag)) begin
            sab <= sab + ACC_W'(pab);
            saa <= saa + ACC_W'(paa);
            sbb <= sbb + ACC_W'(pbb);
            k <= k + 1'b1;
          end
        end
        mwc_pkg::ST_LOAD: begin
          ma <= ld_a;
          mb <= ld_b;
          mp <= '0;
        end
        mwc_pkg::ST_MUL: begin
          if (!mul_done) begin
            if (mb[0]) begin
              mp <= mp + ma;
            end
            ma <= ma << 1;
            mb <= mb >> 1;
          end else begin
            case (op)
              mwc_pkg::OP_NSAB: begin
                term_p <= mp[TW-1:0];
                op <= mwc_pkg::OP_KSA;
              end
              mwc_pkg::OP_KSA: begin
                tmp <= mp[TW-1:0];
                op <= mwc_pkg::OP_KSASB;
              end
              mwc_pkg::OP_KSASB: begin
                num <= num_c;
                op <= mwc_pkg::OP_NSAA;
              end
              mwc_pkg::OP_NSAA: begin
                term_p <= mp[TW-1:0];
                op <= mwc_pkg::OP_KSASA;
              end
              mwc_pkg::OP_KSASA: begin
                vx <= diff_c;
                op <= mwc_pkg::OP_NSBB;
              end
              mwc_pkg::OP_NSBB: begin
                term_p <= mp[TW-1:0];
                op <= mwc_pkg::OP_KSB;
              end
              mwc_pkg::OP_KSB: begin
                tmp <= mp[TW-1:0];
                op <= mwc_pkg::OP_KSBSB;
              end
              mwc_pkg::OP_KSBSB: begin
                // term_p now holds the magnitude of y
                term_p <= vy_mag;
                degen <= degen_c;
                lo <= '0;
                op <= mwc_pkg::OP_XY;
              end
              mwc_pkg::OP_XY: begin
                xy <= mp[2*TW-1:0];
                op <= mwc_pkg::OP_NUM2;
              end
              mwc_pkg::OP_NUM2: begin
                lhs <= mp << mwc_pkg::FRAC_SHIFT;
                bit_idx <= 4'd15;
                op <= mwc_pkg::OP_CAND;
              end
              mwc_pkg::OP_CAND: begin
                if (cand <= mwc_pkg::CAND_MAX && mp <= lhs) begin
                  lo <= cand;
                end
                if (bit_idx != '0) begin
                  bit_idx <= bit_idx - 1'b1;
                end
              end
              default: op <= mwc_pkg::OP_NSAB;
            endcase
          end
        end
        mwc_pkg::ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            degenerate <= degen;
            overflowed <= overflow_seen;
            if (num[TS-1]) begin
              correlation <= signed'(~lo + 16'd1);
            end else begin
              correlation <= signed'((lo > mwc_pkg::CORR_POS_MAX) ? mwc_pkg::CORR_POS_MAX : lo);
            end
            count <= '0;
            sum_a <= '0;
            sum_b <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
          rd_v1 <= 1'b0;
          rd_v2 <= 1'b0;
        end
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BINS))
    else $error("bin count beyond capacity");

  a_kept_cap: assert property (@(posedge clk) disable iff (rst)
    (state == mwc_pkg::ST_LOAD || state == mwc_pkg::ST_MUL) |-> k <= count)
    else $error("kept bins exceed stored bins");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == mwc_pkg::ST_DONE)
    else $error("result without finished frame");

  a_root_cap: assert property (@(posedge clk) disable iff (rst)
    (state == mwc_pkg::ST_DONE) |-> lo <= mwc_pkg::CAND_MAX)
    else $error("root search above full scale");

endmodule
